// File: rtl/itoa_pkg.sv
`timescale 1ns / 1ps

package itoa_pkg;

   localparam int unsigned VALUE_W  = 64;
   localparam int unsigned NUM_DIG  = 20;
   localparam int unsigned DIGITS_W = NUM_DIG * 4;
   localparam int unsigned STEP_W   = 3;

   localparam logic [6:0] CH_ZERO  = 7'h30;
   localparam logic [6:0] CH_A     = 7'h41;
   localparam logic [6:0] CH_MINUS = 7'h2D;
   localparam logic [3:0] DEC_TEN  = 4'd10;
   localparam logic [3:0] BCD_FIVE = 4'd5;
   localparam logic [3:0] BCD_ADJ  = 4'd3;
   localparam logic [4:0] HEX_DIGS = 5'd16;
   localparam logic [4:0] DEC_DIGS = 5'd20;
   localparam logic [5:0] LAST_BIT = 6'd63;

   typedef enum logic [2:0] {
      OP_WAIT   = 3'd0,
      OP_NOP    = 3'd1,
      OP_DABBLE = 3'd2,
      OP_SKIP   = 3'd3,
      OP_SIGN   = 3'd4,
      OP_EMIT   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      C_NEVER  = 3'd0,
      C_ALWAYS = 3'd1,
      C_IDLE   = 3'd2,
      C_HEX    = 3'd3,
      C_BITS   = 3'd4,
      C_LEAD0  = 3'd5,
      C_MORE   = 3'd6
   } cond_type;

   typedef struct packed {
      op_type             op;
      cond_type           cond;
      logic [STEP_W-1:0]  target;
   } ctl_word_type;

   typedef struct packed {
      logic start;
      logic hex;
      logic bits_left;
      logic lead_zero;
      logic more;
   } flags_type;

   localparam logic [STEP_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STEP_W-1:0] ST_DABBLE = 3'd2;
   localparam logic [STEP_W-1:0] ST_SKIP   = 3'd3;
   localparam logic [STEP_W-1:0] ST_EMIT   = 3'd5;

   function automatic ctl_word_type rom_word(input logic [STEP_W-1:0] step);
      ctl_word_type w;
      unique case (step)
         3'd0:    w = '{op: OP_WAIT,   cond: C_IDLE,   target: ST_IDLE};
         3'd1:    w = '{op: OP_NOP,    cond: C_HEX,    target: ST_SKIP};
         3'd2:    w = '{op: OP_DABBLE, cond: C_BITS,   target: ST_DABBLE};
         3'd3:    w = '{op: OP_SKIP,   cond: C_LEAD0,  target: ST_SKIP};
         3'd4:    w = '{op: OP_SIGN,   cond: C_NEVER,  target: ST_IDLE};
         3'd5:    w = '{op: OP_EMIT,   cond: C_MORE,   target: ST_EMIT};
         default: w = '{op: OP_NOP,    cond: C_ALWAYS, target: ST_IDLE};
      endcase
      return w;
   endfunction

endpackage

// File: rtl/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps

// Formats a 64-bit value as ASCII text, one character per rsp_strobe cycle, most
// significant first, with rsp_last and rsp_char_count on the final character. A
// request (req_value, req_mode) is taken when start is high and busy is low;
// busy stays high until the whole text has gone out. The receiver cannot stall:
// characters appear one per cycle with no gaps once emission begins. Decimal
// requests spend most of their time in the 64-step shift-and-add-3 binary-to-BCD
// loop of the microcode; hex requests bypass that loop and go straight to the
// leading-zero skip and the one-character-per-cycle emit loop.
module integer_to_ascii_formatter import itoa_pkg::*; (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic signed [63:0]  req_value,
   input  logic                req_mode,
   output logic                rsp_strobe,
   output logic [6:0]          rsp_ascii_char,
   output logic                rsp_last,
   output logic [4:0]          rsp_char_count
);

   ctl_word_type ctl;
   flags_type    flags;

   logic [DIGITS_W-1:0] digits_ff, digits_in;
   logic [VALUE_W-1:0]  shift_ff, shift_in;
   logic [5:0]          bits_ff, bits_in;
   logic [4:0]          ndig_ff, ndig_in;
   logic [4:0]          total_ff, total_in;
   logic                neg_ff, neg_in;
   logic                strobe_ff, strobe_in;
   logic [6:0]          char_ff, char_in;
   logic                last_ff, last_in;
   logic [4:0]          count_ff, count_in;

   logic [DIGITS_W-1:0] adjusted;
   logic [3:0]          top;
   logic [6:0]          top_char;
   logic [VALUE_W-1:0]  magnitude;
   logic                is_neg;

   itoa_seq u_seq (
      .clock (clock),
      .reset (reset),
      .flags (flags),
      .ctl   (ctl),
      .busy  (busy)
   );

   assign top          = digits_ff[DIGITS_W-1 -: 4];
   assign flags = '{
      start:     start,
      hex:       neg_ff ? 1'b0 : (ndig_ff == HEX_DIGS),
      bits_left: (bits_ff != '0),
      lead_zero: (top == '0) && (ndig_ff > 5'd1),
      more:      (ndig_ff > 5'd1)
   };

   assign is_neg    = !req_mode && req_value[VALUE_W-1];
   assign magnitude = is_neg ? (~req_value) + 64'd1 : req_value;
   assign top_char  = (top < DEC_TEN) ? CH_ZERO + {3'b000, top}
                                      : CH_A + {3'b000, top - DEC_TEN};

   always_comb begin
      for (int i = 0; i < NUM_DIG; i++) begin
         adjusted[i*4 +: 4] = (digits_ff[i*4 +: 4] >= BCD_FIVE)
                            ? digits_ff[i*4 +: 4] + BCD_ADJ : digits_ff[i*4 +: 4];
      end
   end

   always_comb begin
      digits_in = digits_ff;
      shift_in  = shift_ff;
      bits_in   = bits_ff;
      ndig_in   = ndig_ff;
      total_in  = total_ff;
      neg_in    = neg_ff;
      strobe_in = 1'b0;
      char_in   = char_ff;
      last_in   = 1'b0;
      count_in  = '0;
      unique case (ctl.op)
         OP_WAIT: begin
            if (start) begin
               neg_in  = is_neg;
               bits_in = LAST_BIT;
               if (req_mode) begin
                  digits_in = {req_value, 16'h0000};
                  ndig_in   = HEX_DIGS;
               end else begin
                  digits_in = '0;
                  shift_in  = magnitude;
                  ndig_in   = DEC_DIGS;
               end
            end
         end
         OP_DABBLE: begin
            digits_in = {adjusted[DIGITS_W-2:0], shift_ff[VALUE_W-1]};
            shift_in  = {shift_ff[VALUE_W-2:0], 1'b0};
            bits_in   = bits_ff - 6'd1;
         end
         OP_SKIP: begin
            if (flags.lead_zero) begin
               digits_in = {digits_ff[DIGITS_W-5:0], 4'h0};
               ndig_in   = ndig_ff - 5'd1;
            end
         end
         OP_SIGN: begin
            total_in  = ndig_ff + {4'b0000, neg_ff};
            strobe_in = neg_ff;
            char_in   = CH_MINUS;
         end
         OP_EMIT: begin
            strobe_in = 1'b1;
            char_in   = top_char;
            last_in   = !flags.more;
            count_in  = flags.more ? 5'd0 : total_ff;
            digits_in = {digits_ff[DIGITS_W-5:0], 4'h0};
            ndig_in   = ndig_ff - 5'd1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      digits_ff <= digits_in;
      shift_ff  <= shift_in;
      bits_ff   <= bits_in;
      ndig_ff   <= ndig_in;
      total_ff  <= total_in;
      neg_ff    <= neg_in;
      char_ff   <= char_in;
      last_ff   <= last_in;
      count_ff  <= count_in;
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ascii_char = char_ff;
   assign rsp_last       = last_ff;
   assign rsp_char_count = count_ff;

`ifndef SYNTH
   a_count_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> rsp_char_count == 5'd0)
      else $error("char count set on a non-final character");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |-> rsp_char_count >= 5'd1 && rsp_char_count <= DEC_DIGS)
      else $error("char count out of range on final character");
   a_idle_quiet: assert property (@(posedge clock) disable iff (reset)
      !busy |=> !rsp_strobe)
      else $error("character strobed while idle");
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after request");
`endif

endmodule

// File: rtl/itoa_seq.sv
`timescale 1ns / 1ps

module itoa_seq import itoa_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  flags_type    flags,
   output ctl_word_type ctl,
   output logic         busy
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              taken;

   assign ctl  = rom_word(step_ff);
   assign busy = (step_ff != ST_IDLE);

   always_comb begin
      unique case (ctl.cond)
         C_NEVER:  taken = 1'b0;
         C_ALWAYS: taken = 1'b1;
         C_IDLE:   taken = !flags.start;
         C_HEX:    taken = flags.hex;
         C_BITS:   taken = flags.bits_left;
         C_LEAD0:  taken = flags.lead_zero;
         C_MORE:   taken = flags.more;
         default:  taken = 1'b1;
      endcase
      step_in = taken ? ctl.target : step_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= ST_IDLE;
      end else begin
         step_ff <= step_in;
      end
   end

endmodule
